>>> hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the pulse tachometer, speed and gear estimator.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int CNT_W   = 16;
  localparam int GATE_W  = 10;
  localparam int SCALE_W = 15;
  localparam int PROD_W  = CNT_W + SCALE_W;
  localparam int REM_W   = GATE_W;
  localparam int BIT_W   = 4;
  localparam int GEAR_W  = 3;
  localparam int RATIO_W = 7;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;
  localparam logic [SCALE_W-1:0] RPM_SCALE   = 15'd30000;
  localparam logic [SCALE_W-1:0] SPEED_SCALE = 15'd4500;
  localparam logic [BIT_W-1:0]   BIT_LAST    = 4'd15;
  localparam logic [IDX_W-1:0]   IDX_LAST    = 3'd4;
  localparam logic [GEAR_W-1:0]  GEAR_NONE   = 3'd0;
  localparam logic [GEAR_W-1:0]  GEAR_TOP    = 3'd6;
  localparam logic [CNT_W-1:0]   MIN_TENTHS  = 16'd10;

  localparam logic [GATE_W-1:0] GATE_RESET  = 10'd100;
  localparam logic [CNT_W-1:0]  SHIFT_RESET = 16'd6500;
  localparam logic [CNT_W-1:0]  IDLE_RESET  = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_RPM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RPM  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_GSTART,
    ST_GWAIT,
    ST_DONE
  } pts_state_t;

  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_start;
    logic div_step;
  } pts_lane_ctl_t;

  // rpm*10 against speed_tenths times these, first match wins
  function automatic logic [RATIO_W-1:0] gear_ratio(input logic [IDX_W-1:0] idx);
    logic [RATIO_W-1:0] r;
    unique case (idx)
      3'd0:    r = 7'd100;
      3'd1:    r = 7'd65;
      3'd2:    r = 7'd48;
      3'd3:    r = 7'd38;
      default: r = 7'd30;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/pts_gate.sv
// ----------------------------------------------------------------------------
// pts_gate
// Pulse counters and millisecond gate; flags the item that closes the gate.
// ----------------------------------------------------------------------------
module pts_gate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          engine_pulse,
  input  logic                          wheel_pulse,
  input  logic                          ms_tick,
  input  logic [pts_pkg::GATE_W-1:0]    gate_eff,
  output logic                          close,
  output logic [pts_pkg::CNT_W-1:0]     engine_total,
  output logic [pts_pkg::CNT_W-1:0]     wheel_total
);

  logic [pts_pkg::GATE_W-1:0] tick_count_r, tick_count_nxt, tick_inc;
  logic [pts_pkg::CNT_W-1:0]  engine_count_r, engine_count_nxt;
  logic [pts_pkg::CNT_W-1:0]  wheel_count_r, wheel_count_nxt;

  always_comb begin
    engine_total = engine_count_r;
    wheel_total  = wheel_count_r;
    if (engine_pulse && engine_count_r != pts_pkg::CNT_MAX) begin
      engine_total = engine_count_r + 1'b1;
    end
    if (wheel_pulse && wheel_count_r != pts_pkg::CNT_MAX) begin
      wheel_total = wheel_count_r + 1'b1;
    end
    tick_inc = tick_count_r + 1'b1;
    close    = accept && ms_tick && (tick_inc >= gate_eff);

    tick_count_nxt   = tick_count_r;
    engine_count_nxt = engine_count_r;
    wheel_count_nxt  = wheel_count_r;
    if (close) begin
      tick_count_nxt   = '0;
      engine_count_nxt = '0;
      wheel_count_nxt  = '0;
    end else if (accept) begin
      engine_count_nxt = engine_total;
      wheel_count_nxt  = wheel_total;
      if (ms_tick) begin
        tick_count_nxt = tick_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r   <= '0;
      engine_count_r <= '0;
      wheel_count_r  <= '0;
    end else begin
      tick_count_r   <= tick_count_nxt;
      engine_count_r <= engine_count_nxt;
      wheel_count_r  <= wheel_count_nxt;
    end
  end

endmodule

>>> hdl/pts_lane.sv
// ----------------------------------------------------------------------------
// pts_lane
// Bit-serial count*scale, then restoring division by the gate, saturating.
// ----------------------------------------------------------------------------
module pts_lane (
  input  logic                          clk,
  input  pts_pkg::pts_lane_ctl_t        ctl,
  input  logic [pts_pkg::CNT_W-1:0]     count,
  input  logic [pts_pkg::SCALE_W-1:0]   scale,
  input  logic [pts_pkg::GATE_W-1:0]    gate,
  output logic [pts_pkg::CNT_W-1:0]     rate
);

  logic [pts_pkg::CNT_W-1:0]  cnt_sh_r, cnt_sh_nxt;
  logic [pts_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [pts_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic                       sat_r, sat_nxt;
  logic [pts_pkg::REM_W:0]    trial;
  logic                       qbit;

  always_comb begin
    cnt_sh_nxt = cnt_sh_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    sat_nxt    = sat_r;
    trial      = {rem_r, prod_r[pts_pkg::CNT_W-1]};
    qbit       = (trial >= {1'b0, gate});
    priority if (ctl.load) begin
      cnt_sh_nxt = count;
      prod_nxt   = '0;
    end else if (ctl.mul_step) begin
      cnt_sh_nxt = {cnt_sh_r[pts_pkg::CNT_W-2:0], 1'b0};
      prod_nxt   = {prod_r[pts_pkg::PROD_W-2:0], 1'b0}
                 + (cnt_sh_r[pts_pkg::CNT_W-1] ? pts_pkg::PROD_W'(scale) : '0);
    end else if (ctl.div_start) begin
      // quotient of 2^16 or more saturates
      sat_nxt = (prod_r[pts_pkg::PROD_W-1:pts_pkg::CNT_W] >= pts_pkg::SCALE_W'(gate));
      rem_nxt = prod_r[pts_pkg::CNT_W +: pts_pkg::REM_W];
    end else if (ctl.div_step) begin
      rem_nxt  = qbit ? pts_pkg::REM_W'(trial - {1'b0, gate}) : trial[pts_pkg::REM_W-1:0];
      prod_nxt = {prod_r[pts_pkg::PROD_W-1:pts_pkg::CNT_W],
                  prod_r[pts_pkg::CNT_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    cnt_sh_r <= cnt_sh_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    sat_r    <= sat_nxt;
  end

  assign rate = sat_r ? pts_pkg::CNT_MAX : prod_r[pts_pkg::CNT_W-1:0];

endmodule

>>> hdl/pts_gear.sv
// ----------------------------------------------------------------------------
// pts_gear
// Gear estimate: one ratio threshold compared per cycle.
// ----------------------------------------------------------------------------
module pts_gear (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pts_pkg::CNT_W-1:0]     rpm,
  input  logic [pts_pkg::CNT_W-1:0]     tenths,
  input  logic [pts_pkg::CNT_W-1:0]     idle_rpm,
  output logic                          done,
  output logic [pts_pkg::GEAR_W-1:0]    gear
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [pts_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic [pts_pkg::GEAR_W-1:0]         gear_r, gear_nxt;
  logic [pts_pkg::CNT_W-1:0]          rpm_r, rpm_nxt, sp_r, sp_nxt;
  logic [pts_pkg::CNT_W+3:0]          r10;
  logic [pts_pkg::CNT_W+pts_pkg::RATIO_W-1:0] thr;

  always_comb begin
    r10 = {1'b0, rpm_r, 3'b000} + {3'b000, rpm_r, 1'b0};
    thr = {{pts_pkg::CNT_W{1'b0}}, pts_pkg::gear_ratio(idx_r)}
        * {{pts_pkg::RATIO_W{1'b0}}, sp_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    gear_nxt = gear_r;
    rpm_nxt  = rpm_r;
    sp_nxt   = sp_r;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      rpm_nxt  = rpm;
      sp_nxt   = tenths;
    end else if (busy_r) begin
      priority if (sp_r < pts_pkg::MIN_TENTHS || rpm_r < idle_rpm) begin
        gear_nxt = pts_pkg::GEAR_NONE;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if ({3'b000, r10} > thr) begin
        gear_nxt = idx_r + 1'b1;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (idx_r == pts_pkg::IDX_LAST) begin
        gear_nxt = pts_pkg::GEAR_TOP;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    idx_r  <= idx_nxt;
    gear_r <= gear_nxt;
    rpm_r  <= rpm_nxt;
    sp_r   <= sp_nxt;
  end

  assign done = done_r;
  assign gear = gear_r;

endmodule

>>> hdl/pulse_tach_speed_gear_estimator.sv
// ----------------------------------------------------------------------------
// pulse_tach_speed_gear_estimator
// Counts engine and wheel pulses over a millisecond gate and reports rpm,
// road speed in tenths of mph, an estimated gear and a shift flag.
//
//   channel  signals                                          handshake
//   in       engine_pulse, wheel_pulse, ms_tick               in_valid / in_stall
//   out      engine_rpm, speed_tenths, gear, shift_now        out_valid / out_stall
//   cfg      cfg_index, cfg_wdata                             cfg_we
//
// an item that does not close the gate is taken without raising in_stall
// the closing item starts 16 multiply and 16 divide steps on two bit-serial
// lanes, then 1 to 5 gear compares, before the result is loaded
// in_stall is high from the closing transfer until the result is loaded, and
// longer while a stalled result still holds the output register
// a result waiting in the output register does not block new items
// reset is synchronous and restores the register defaults and clears counts
// ----------------------------------------------------------------------------
module pulse_tach_speed_gear_estimator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_engine_pulse,
  input  logic                              in_wheel_pulse,
  input  logic                              in_ms_tick,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       out_engine_rpm,
  output logic [15:0]                       out_speed_tenths,
  output logic [2:0]                        out_gear,
  output logic                              out_shift_now,
  input  logic                              cfg_we,
  input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pts_pkg::CFG_W-1:0]         cfg_wdata
);

  pts_pkg::pts_state_t state_r, state_nxt;
  logic [pts_pkg::BIT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [pts_pkg::GATE_W-1:0] gate_ms_r, gate_r, gate_nxt, gate_eff;
  logic [pts_pkg::CNT_W-1:0]  shift_rpm_r, idle_rpm_r;
  logic                       in_xfer, close, out_free, out_load, gear_start, gear_done;
  logic [pts_pkg::CNT_W-1:0]  engine_total, wheel_total, rpm, tenths;
  logic [pts_pkg::GEAR_W-1:0] gear;
  pts_pkg::pts_lane_ctl_t     lane_ctl;

  logic                       out_valid_r;
  logic [pts_pkg::CNT_W-1:0]  out_rpm_r, out_tenths_r;
  logic [pts_pkg::GEAR_W-1:0] out_gear_r;
  logic                       out_shift_r;

  assign gate_eff = (gate_ms_r == '0) ? pts_pkg::GATE_W'(1) : gate_ms_r;
  assign in_stall = (state_r != pts_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_ms_r   <= pts_pkg::GATE_RESET;
      shift_rpm_r <= pts_pkg::SHIFT_RESET;
      idle_rpm_r  <= pts_pkg::IDLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pts_pkg::CFG_GATE_MS:   gate_ms_r   <= cfg_wdata[pts_pkg::GATE_W-1:0];
        pts_pkg::CFG_SHIFT_RPM: shift_rpm_r <= cfg_wdata;
        pts_pkg::CFG_IDLE_RPM:  idle_rpm_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pts_gate u_gate (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_xfer),
    .engine_pulse (in_engine_pulse),
    .wheel_pulse  (in_wheel_pulse),
    .ms_tick      (in_ms_tick),
    .gate_eff     (gate_eff),
    .close        (close),
    .engine_total (engine_total),
    .wheel_total  (wheel_total)
  );

  pts_lane u_rpm_lane (
    .clk   (clk),
    .ctl   (lane_ctl),
    .count (engine_total),
    .scale (pts_pkg::RPM_SCALE),
    .gate  (gate_r),
    .rate  (rpm)
  );

  pts_lane u_speed_lane (
    .clk   (clk),
    .ctl   (lane_ctl),
    .count (wheel_total),
    .scale (pts_pkg::SPEED_SCALE),
    .gate  (gate_r),
    .rate  (tenths)
  );

  pts_gear u_gear (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (gear_start),
    .rpm      (rpm),
    .tenths   (tenths),
    .idle_rpm (idle_rpm_r),
    .done     (gear_done),
    .gear     (gear)
  );

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    gate_nxt    = gate_r;
    lane_ctl    = '0;
    gear_start  = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      pts_pkg::ST_IDLE: begin
        if (close) begin
          lane_ctl.load = 1'b1;
          gate_nxt      = gate_eff;
          bit_cnt_nxt   = '0;
          state_nxt     = pts_pkg::ST_MUL;
        end
      end
      pts_pkg::ST_MUL: begin
        lane_ctl.mul_step = 1'b1;
        bit_cnt_nxt       = bit_cnt_r + 1'b1;
        if (bit_cnt_r == pts_pkg::BIT_LAST) begin
          state_nxt = pts_pkg::ST_CHK;
        end
      end
      pts_pkg::ST_CHK: begin
        lane_ctl.div_start = 1'b1;
        bit_cnt_nxt        = '0;
        state_nxt          = pts_pkg::ST_DIV;
      end
      pts_pkg::ST_DIV: begin
        lane_ctl.div_step = 1'b1;
        bit_cnt_nxt       = bit_cnt_r + 1'b1;
        if (bit_cnt_r == pts_pkg::BIT_LAST) begin
          state_nxt = pts_pkg::ST_GSTART;
        end
      end
      pts_pkg::ST_GSTART: begin
        gear_start = 1'b1;
        state_nxt  = pts_pkg::ST_GWAIT;
      end
      pts_pkg::ST_GWAIT: begin
        if (gear_done) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = pts_pkg::ST_IDLE;
          end else begin
            state_nxt = pts_pkg::ST_DONE;
          end
        end
      end
      pts_pkg::ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = pts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pts_pkg::ST_IDLE;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    gate_r <= gate_nxt;
    if (out_load) begin
      out_rpm_r    <= rpm;
      out_tenths_r <= tenths;
      out_gear_r   <= gear;
      out_shift_r  <= (rpm >= shift_rpm_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_engine_rpm   = out_rpm_r;
  assign out_speed_tenths = out_tenths_r;
  assign out_gear         = out_gear_r;
  assign out_shift_now    = out_shift_r;

endmodule

>>> hdl/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_engine_rpm,
  input logic [15:0] out_speed_tenths,
  input logic [2:0]  out_gear
);

  // a stalled transfer keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled transfer keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_engine_rpm) && $stable(out_speed_tenths)
                               && $stable(out_gear))
    else $error("result changed while stalled");

  // gear never exceeds the top gear
  a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gear <= 3'd6)
    else $error("gear out of range");

  // a nonzero gear needs road speed of at least 1.0 mph
  a_gear_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gear != 3'd0 |-> out_speed_tenths >= 16'd10)
    else $error("gear reported while stopped");

endmodule

bind pulse_tach_speed_gear_estimator pts_checker u_pts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_engine_rpm   (out_engine_rpm),
  .out_speed_tenths (out_speed_tenths),
  .out_gear         (out_gear)
);

>>> dv/pulse_tach_speed_gear_estimator_tb.sv
// ----------------------------------------------------------------------------
// pulse_tach_speed_gear_estimator_tb
// Drives pulse and tick items through the estimator and checks every gate
// reading against a cycle-free prediction of counts, rpm, road speed, gear and
// shift flag. It covers reset defaults, directed corner cases (a gate of zero,
// a shortened gate, speed below 1 mph, saturated rpm), register writes
// with extreme values, and random phases with idling and a long output hold.
// ----------------------------------------------------------------------------
module pulse_tach_speed_gear_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RPM_PER_PULSE   = 30000;
  localparam int unsigned TENTHS_PER_PULSE = 4500;
  localparam int unsigned GEAR_RATIO [5]  = '{100, 65, 48, 38, 30};
  localparam logic [pts_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [15:0] rpm;
    logic [15:0] tenths;
    logic [2:0]  gear;
    logic        shift;
  } tach_reading_t;

  class tach_scoreboard;
    logic [pts_pkg::GATE_W-1:0] gate_ms;
    logic [pts_pkg::CNT_W-1:0]  shift_rpm;
    logic [pts_pkg::CNT_W-1:0]  idle_rpm;
    logic [pts_pkg::GATE_W-1:0] ticks;
    logic [pts_pkg::CNT_W-1:0]  engine_cnt;
    logic [pts_pkg::CNT_W-1:0]  wheel_cnt;
    tach_reading_t     readings_due[$];
    int n_errors;
    int n_inputs;
    int n_checked;

    function new();
      gate_ms    = 10'd100;
      shift_rpm  = 16'd6500;
      idle_rpm   = 16'd500;
      ticks      = '0;
      engine_cnt = '0;
      wheel_cnt  = '0;
    endfunction

    function void write_reg(logic [pts_pkg::CFG_IDX_W-1:0] idx,
                            logic [pts_pkg::CFG_W-1:0] data);
      case (idx)
        pts_pkg::CFG_GATE_MS:   gate_ms = data[pts_pkg::GATE_W-1:0];
        pts_pkg::CFG_SHIFT_RPM: shift_rpm = data;
        pts_pkg::CFG_IDLE_RPM:  idle_rpm = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] scaled_rate(logic [15:0] cnt, int unsigned scale,
                                      logic [pts_pkg::GATE_W-1:0] gate);
      longint unsigned q;
      q = cnt;
      q = q * scale / gate;
      return (q > 65535) ? 16'hFFFF : 16'(q);
    endfunction

    function logic [2:0] gear_of(logic [15:0] rpm, logic [15:0] tenths);
      longint unsigned r10;
      longint unsigned s;
      if (tenths < 16'd10 || rpm < idle_rpm) return pts_pkg::GEAR_NONE;
      r10 = rpm;
      r10 = r10 * 10;
      s = tenths;
      for (int i = 0; i < 5; i++) begin
        if (r10 > GEAR_RATIO[i] * s) return 3'(i + 1);
      end
      return pts_pkg::GEAR_TOP;
    endfunction

    function void note_input(logic engine, logic wheel, logic tick);
      logic [pts_pkg::GATE_W-1:0] gate;
      tach_reading_t r;
      n_inputs++;
      if (engine && engine_cnt != 16'hFFFF) engine_cnt++;
      if (wheel && wheel_cnt != 16'hFFFF) wheel_cnt++;
      if (!tick) return;
      gate = (gate_ms == '0) ? 10'd1 : gate_ms;
      ticks = ticks + 10'd1;
      if (ticks < gate) return;
      r.rpm    = scaled_rate(engine_cnt, RPM_PER_PULSE, gate);
      r.tenths = scaled_rate(wheel_cnt, TENTHS_PER_PULSE, gate);
      r.gear   = gear_of(r.rpm, r.tenths);
      r.shift  = (r.rpm >= shift_rpm);
      readings_due.push_back(r);
      ticks      = '0;
      engine_cnt = '0;
      wheel_cnt  = '0;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_reading(tach_reading_t got);
      tach_reading_t want;
      if (readings_due.size() == 0) begin
        $error("unexpected reading: rpm %0d tenths %0d gear %0d shift %0d",
               got.rpm, got.tenths, got.gear, got.shift);
        n_errors++;
        return;
      end
      want = readings_due.pop_front();
      n_checked++;
      check_field("engine_rpm", want.rpm, got.rpm);
      check_field("speed_tenths", want.tenths, got.tenths);
      check_field("gear", want.gear, got.gear);
      check_field("shift_now", want.shift, got.shift);
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_engine_pulse = 1'b0;
  logic in_wheel_pulse = 1'b0;
  logic in_ms_tick = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_engine_rpm;
  logic [15:0] out_speed_tenths;
  logic [2:0]  out_gear;
  logic        out_shift_now;
  logic cfg_we = 1'b0;
  logic [pts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pts_pkg::CFG_W-1:0]     cfg_wdata = '0;

  tach_scoreboard sb;
  bit send_gaps;
  bit stall_idling;
  bit hold_req;
  int n_reg_writes;
  int unsigned cycles;

  pulse_tach_speed_gear_estimator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_engine_pulse  (in_engine_pulse),
    .in_wheel_pulse   (in_wheel_pulse),
    .in_ms_tick       (in_ms_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_engine_rpm   (out_engine_rpm),
    .out_speed_tenths (out_speed_tenths),
    .out_gear         (out_gear),
    .out_shift_now    (out_shift_now),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_idling && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_reading('{out_engine_rpm, out_speed_tenths, out_gear, out_shift_now});
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic send_item(input logic engine, input logic wheel, input logic tick);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_engine_pulse <= engine;
    in_wheel_pulse  <= wheel;
    in_ms_tick      <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(engine, wheel, tick);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pts_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    n_reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] gate_data, input logic [15:0] shift_data,
                          input logic [15:0] idle_data);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(pts_pkg::CFG_GATE_MS, gate_data);
    write_reg(pts_pkg::CFG_SHIFT_RPM, shift_data);
    write_reg(pts_pkg::CFG_IDLE_RPM, idle_data);
  endtask

  task automatic random_phase(input int n_items, input bit quiet, input bit squeeze);
    int tick_pct;
    int engine_pct;
    int wheel_pct;
    logic [15:0] gate_data;
    logic [15:0] shift_data;
    logic [15:0] idle_data;
    gate_data = {6'($urandom), 10'($urandom_range(1, 24))};
    if ($urandom_range(0, 5) == 0) gate_data[9:0] = 10'($urandom_range(0, 1023));
    if (squeeze) gate_data[9:0] = 10'd1;
    case ($urandom_range(0, 3))
      0: shift_data = 16'd0;
      1: shift_data = 16'hFFFF;
      default: shift_data = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0: idle_data = 16'd0;
      1: idle_data = 16'hFFFF;
      default: idle_data = 16'($urandom_range(0, 8000));
    endcase
    set_regs(gate_data, shift_data, idle_data);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNMAPPED, 16'($urandom));
    tick_pct   = $urandom_range(5, 60);
    if (squeeze) tick_pct = 60;
    engine_pct = $urandom_range(0, (tick_pct * 2 > 100) ? 100 : tick_pct * 2);
    wheel_pct  = engine_pct * $urandom_range(50, 250) / 100;
    if (wheel_pct > 100) wheel_pct = 100;
    if ($urandom_range(0, 3) == 0) begin
      engine_pct = $urandom_range(0, 100);
      wheel_pct  = $urandom_range(0, 100);
    end
    send_gaps    = !quiet && $urandom_range(0, 3) != 0;
    stall_idling = !quiet && $urandom_range(0, 3) != 0;
    if (squeeze) hold_req = 1'b1;
    repeat (n_items) send_item(chance(engine_pct), chance(wheel_pct), chance(tick_pct));
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    send_gaps    = 1'b1;
    stall_idling = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // one gate under the reset register values
    repeat (100) send_item(1'($urandom), 1'($urandom), 1'b1);

    // gate of zero acts as one; upper data bits dropped
    set_regs(16'hFC00, 16'd0, 16'd0);
    send_item(1'b0, 1'b0, 1'b0);
    send_item(1'b1, 1'b0, 1'b0);
    send_item(1'b0, 1'b1, 1'b0);
    send_item(1'b1, 1'b1, 1'b1);
    send_item(1'b0, 1'b0, 1'b1);
    send_item(1'b1, 1'b1, 1'b1);

    // extreme thresholds, unmapped index ignored, rpm saturation
    set_regs(16'd1, 16'hFFFF, 16'hFFFF);
    write_reg(CFG_UNMAPPED, 16'hFFFF);
    send_item(1'b1, 1'b0, 1'b1);
    send_item(1'b1, 1'b0, 1'b0);
    send_item(1'b1, 1'b0, 1'b0);
    send_item(1'b1, 1'b1, 1'b1);

    // gate shortened below the running tick count
    set_regs(16'd5, 16'd6500, 16'd500);
    repeat (3) send_item(1'b0, 1'b0, 1'b1);
    set_regs(16'd2, 16'd6500, 16'd500);
    send_item(1'b1, 1'b1, 1'b1);

    // road speed below 1 mph
    set_regs(16'd500, 16'd6500, 16'd0);
    repeat (499) send_item(1'b0, 1'b0, 1'b1);
    send_item(1'b1, 1'b1, 1'b1);

    for (int p = 0; p < 12; p++) random_phase(100, p >= 9, p == 4);

    wait_drained();
    $display("%0d input transfers, %0d gate readings checked, %0d register writes",
             sb.n_inputs, sb.n_checked, n_reg_writes);
    if (sb.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
